// ===== src/half_cell_glyph_renderer_top_assert.svh =====
// Assertion macros for the half-cell glyph renderer checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef HALF_CELL_GLYPH_RENDERER_TOP_ASSERT_SVH
`define HALF_CELL_GLYPH_RENDERER_TOP_ASSERT_SVH

// Same-cycle implication.
`define HCGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HCGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hcgr_pkg.sv =====
// Shared types and constants for the half-cell glyph renderer.
// No dependencies.
`timescale 1ns / 1ps
package hcgr_pkg;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_PUT  = 2'd1;
  localparam logic [1:0] ACT_PAIR = 2'd2;

  localparam logic TGT_BITMAP = 1'b0;
  localparam logic TGT_COLOR  = 1'b1;

  localparam logic [12:0] BITMAP_BYTES  = 13'd8000;
  localparam logic [12:0] CELLS_PER_ROW = 13'd40;
  localparam logic [12:0] BYTES_PER_ROW = 13'd320;
  localparam logic [7:0]  FIRST_CODE    = 8'd32;
  localparam logic [7:0]  SPACE_CODE    = 8'd32;
  localparam logic [7:0]  MASK_HI       = 8'hF0;
  localparam logic [7:0]  MASK_LO       = 8'h0F;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_COLOR = 6'b000100,
    ST_RD_A  = 6'b001000,
    ST_RD_B  = 6'b010000,
    ST_WR    = 6'b100000
  } state_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic emit_color;
    logic rd_a;
    logic rd_b;
    logic emit_line;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic draw_ok;
    logic is_pair;
    logic out_free;
    logic line_last;
  } status_t;

endpackage

// ===== src/hcgr_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module hcgr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/hcgr_ctrl.sv =====
// Sequencer for the renderer: clear pass, accept, color write, per-line reads and writes.
// Depends on hcgr_pkg.
`timescale 1ns / 1ps
module hcgr_ctrl
  import hcgr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && st.draw_ok) state_nxt = ST_COLOR;
      end
      ST_COLOR: begin
        if (st.out_free) begin
          cmd.emit_color = 1'b1;
          state_nxt      = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd.rd_a  = 1'b1;
        state_nxt = st.is_pair ? ST_RD_B : ST_WR;
      end
      ST_RD_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (st.out_free) begin
          cmd.emit_line = 1'b1;
          state_nxt     = st.line_last ? ST_IDLE : ST_RD_A;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/hcgr_datapath.sv =====
// Datapath: item decode, font store, bitmap mirror, line merge and output register.
// Depends on hcgr_pkg and hcgr_ram.
`timescale 1ns / 1ps
module hcgr_datapath
  import hcgr_pkg::*;
#(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 25,
  parameter int GLYPH_COUNT  = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic [1:0]  in_action,
  input  logic [6:0]  in_column,
  input  logic [4:0]  in_row,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_second_code,
  input  logic [3:0]  in_ink_color,
  input  logic [6:0]  in_line_length,
  input  logic [9:0]  in_font_address,
  input  logic [7:0]  in_font_byte,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        out_target,
  output logic [12:0] out_address,
  output logic [7:0]  out_data,
  output logic        out_last
);

  localparam int GW         = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int FW         = GW + 3;
  localparam int FONT_BYTES = GLYPH_COUNT * 8;

  function automatic logic [GW-1:0] glyph_num(input logic [7:0] code);
    logic [7:0] off;
    off = code - FIRST_CODE;
    if (code >= FIRST_CODE && {1'b0, off} < 9'(GLYPH_COUNT)) begin
      return GW'(off);
    end
    return '0;
  endfunction

  logic          is_load, is_put, is_pair, row_ok, col_ok_put, col_ok_pair;
  logic          fa_ok, left_on, right_on;
  logic [5:0]    cell_idx;
  logic [6:0]    left_col;
  logic [7:0]    code_l, code_r;
  logic [12:0]   color_addr, base_addr, line_addr;

  logic          pair_r, odd_r;
  logic [3:0]    ink_r;
  logic [12:0]   color_addr_r, base_r, clr_cnt_r;
  logic [GW-1:0] lg_r, rg_r;
  logic [2:0]    line_r;
  logic [7:0]    left_r;

  logic          out_valid_r, out_target_r, out_last_r;
  logic [12:0]   out_address_r;
  logic [7:0]    out_data_r;

  logic          font_we, font_re;
  logic [FW-1:0] font_addr;
  logic [7:0]    font_rdata;
  logic          mir_we;
  logic [12:0]   mir_addr;
  logic [7:0]    mir_wdata, mir_rdata, merged;

  assign is_load     = (in_action == ACT_LOAD);
  assign is_put      = (in_action == ACT_PUT);
  assign is_pair     = (in_action == ACT_PAIR);
  assign cell_idx    = in_column[6:1];
  assign left_col    = {cell_idx, 1'b0};
  assign row_ok      = {3'b000, in_row} < 8'(TEXT_ROWS);
  assign col_ok_put  = {1'b0, in_column} < 8'(TEXT_COLUMNS);
  assign col_ok_pair = {1'b0, left_col} < 8'(TEXT_COLUMNS);
  assign fa_ok       = {2'b00, in_font_address} < 12'(FONT_BYTES);
  assign left_on     = {1'b0, left_col} < {1'b0, in_line_length};
  assign right_on    = ({1'b0, left_col} + 8'd1) < {1'b0, in_line_length};
  assign code_l      = (is_pair && !left_on) ? SPACE_CODE : in_char_code;
  assign code_r      = right_on ? in_second_code : SPACE_CODE;
  assign color_addr  = 13'(13'(in_row) * CELLS_PER_ROW + 13'(cell_idx));
  assign base_addr   = 13'(13'(in_row) * BYTES_PER_ROW + 13'({cell_idx, 3'b000}));
  assign line_addr   = 13'(base_r + 13'(line_r));

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pair_r       <= is_pair;
      odd_r        <= in_column[0];
      ink_r        <= in_ink_color;
      color_addr_r <= color_addr;
      base_r       <= base_addr;
      lg_r         <= glyph_num(code_l);
      rg_r         <= glyph_num(code_r);
    end
    if (cmd.rd_b) begin
      left_r <= font_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      line_r    <= '0;
    end else begin
      if (cmd.clr) clr_cnt_r <= 13'(clr_cnt_r + 13'd1);
      if (cmd.take) begin
        line_r <= '0;
      end else if (cmd.emit_line) begin
        line_r <= 3'(line_r + 3'd1);
      end
    end
  end

  assign font_we   = cmd.take && is_load && fa_ok;
  assign font_re   = cmd.rd_a || cmd.rd_b;
  assign font_addr = cmd.take ? FW'(in_font_address) :
                     cmd.rd_b ? {rg_r, line_r} : {lg_r, line_r};

  hcgr_ram #(
    .WIDTH  (8),
    .DEPTH  (FONT_BYTES),
    .ADDR_W (FW)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .re    (font_re),
    .addr  (font_addr),
    .wdata (in_font_byte),
    .rdata (font_rdata)
  );

  always_comb begin
    if (pair_r) begin
      merged = (left_r & MASK_HI) | (font_rdata >> 4);
    end else if (odd_r) begin
      merged = (mir_rdata & MASK_HI) | (font_rdata >> 4);
    end else begin
      merged = (mir_rdata & MASK_LO) | (font_rdata & MASK_HI);
    end
  end

  assign mir_we    = cmd.clr || cmd.emit_line;
  assign mir_addr  = cmd.clr ? clr_cnt_r : line_addr;
  assign mir_wdata = cmd.clr ? 8'h00 : merged;

  hcgr_ram #(
    .WIDTH  (8),
    .DEPTH  (int'(BITMAP_BYTES)),
    .ADDR_W (13)
  ) u_mirror (
    .clk   (clk),
    .we    (mir_we),
    .re    (cmd.rd_a),
    .addr  (mir_addr),
    .wdata (mir_wdata),
    .rdata (mir_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_color || cmd.emit_line) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_color) begin
      out_target_r  <= TGT_COLOR;
      out_address_r <= color_addr_r;
      out_data_r    <= {ink_r, 4'b0000};
      out_last_r    <= 1'b0;
    end else if (cmd.emit_line) begin
      out_target_r  <= TGT_BITMAP;
      out_address_r <= line_addr;
      out_data_r    <= merged;
      out_last_r    <= (line_r == 3'd7);
    end
  end

  assign st.clr_done  = (clr_cnt_r == 13'(BITMAP_BYTES - 13'd1));
  assign st.draw_ok   = row_ok && ((is_put && col_ok_put) || (is_pair && col_ok_pair));
  assign st.is_pair   = pair_r;
  assign st.out_free  = !out_valid_r || !out_stall;
  assign st.line_last = (line_r == 3'd7);

  assign out_valid   = out_valid_r;
  assign out_target  = out_target_r;
  assign out_address = out_address_r;
  assign out_data    = out_data_r;
  assign out_last    = out_last_r;

endmodule

// ===== src/half_cell_glyph_renderer_top.sv =====
// Half-cell glyph renderer: one transfer in, up to nine byte-write transfers out.
// Load writes a font byte. Put and pair write the color byte, then for each glyph line
// read the font store (left, then right glyph for a pair, as the store is single-port)
// and merge and write the line. Output stalls hold the flow; the next item is taken
// after the ninth write. Reset is synchronous; afterwards the bitmap mirror is cleared
// with in_stall high.
`timescale 1ns / 1ps
module half_cell_glyph_renderer_top
  import hcgr_pkg::*;
#(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 25,
  parameter int GLYPH_COUNT  = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [6:0]  in_column,
  input  logic [4:0]  in_row,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_second_code,
  input  logic [3:0]  in_ink_color,
  input  logic [6:0]  in_line_length,
  input  logic [9:0]  in_font_address,
  input  logic [7:0]  in_font_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_target,
  output logic [12:0] out_address,
  output logic [7:0]  out_data,
  output logic        out_last
);

  cmd_t    cmd;
  status_t st;

  hcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  hcgr_datapath #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .GLYPH_COUNT  (GLYPH_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_action       (in_action),
    .in_column       (in_column),
    .in_row          (in_row),
    .in_char_code    (in_char_code),
    .in_second_code  (in_second_code),
    .in_ink_color    (in_ink_color),
    .in_line_length  (in_line_length),
    .in_font_address (in_font_address),
    .in_font_byte    (in_font_byte),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_target      (out_target),
    .out_address     (out_address),
    .out_data        (out_data),
    .out_last        (out_last)
  );

endmodule

// ===== src/hcgr_checker.sv =====
// Port-level checks for the half-cell glyph renderer, bound to the top level.
// Depends on hcgr_pkg and half_cell_glyph_renderer_top_assert.svh.
`timescale 1ns / 1ps
`include "half_cell_glyph_renderer_top_assert.svh"
module hcgr_checker
  import hcgr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_target,
  input logic [12:0] out_address,
  input logic [7:0]  out_data,
  input logic        out_last
);

  `HCGR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_address) && $stable(out_data) && $stable(out_target) && $stable(out_last), "stalled transfer changed")
  `HCGR_ASSERT_IMP(a_color_form, out_valid && out_target == TGT_COLOR, !out_last && out_data[3:0] == 4'h0, "malformed color write")
  `HCGR_ASSERT_IMP(a_bitmap_range, out_valid && out_target == TGT_BITMAP, out_address < BITMAP_BYTES, "bitmap address out of range")
  `HCGR_ASSERT_NXT(a_draw_busy, out_valid && !out_stall && out_target == TGT_COLOR, in_stall, "input taken during a draw")

endmodule

bind half_cell_glyph_renderer_top hcgr_checker u_hcgr_checker (.*);
